/* design/acthr_pkg.sv */
`timescale 1ns / 1ps

package acthr_pkg;

  // Field widths of one item.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned FILT_W   = SAMPLE_W + FRAC_W;

  // Configuration port.
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_THRESH_MIN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH_MAX  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH_INIT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DARK_LEVEL  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DELTA_DEF   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DELTA_LOW   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_PAUSED      = 3'd7;

  // Register values after reset.
  localparam logic [SAMPLE_W-1:0] THRESH_MIN_RST  = 16'd0;
  localparam logic [SAMPLE_W-1:0] THRESH_MAX_RST  = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] THRESH_INIT_RST = 16'd800;
  localparam logic [SAMPLE_W-1:0] DARK_LEVEL_RST  = 16'd250;
  localparam logic [SAMPLE_W-1:0] DELTA_DEF_RST   = 16'd35;
  localparam logic [SAMPLE_W-1:0] DELTA_LOW_RST   = 16'd20;
  localparam logic [SAMPLE_W-1:0] INTERVAL_RST    = 16'd1000;

  localparam int unsigned NUM_SENSORS_DEF = 4;

  // Per-item control handed from the top level to the send scheduler.
  typedef struct packed {
    logic en;
    logic any_change;
    logic paused;
  } sched_ctl_t;

endpackage

/* design/acthr_channel.sv */
`timescale 1ns / 1ps

module acthr_channel (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic [acthr_pkg::SAMPLE_W-1:0]   raw,
  input  logic [acthr_pkg::SAMPLE_W-1:0]   delta,
  input  logic [acthr_pkg::SAMPLE_W-1:0]   thr_lo,
  input  logic [acthr_pkg::SAMPLE_W-1:0]   thr_hi,
  output logic [acthr_pkg::SAMPLE_W-1:0]   thresh,
  output logic                             changed
);

  localparam int unsigned SW = acthr_pkg::SAMPLE_W;
  localparam int unsigned FW = acthr_pkg::FILT_W;

  logic [FW-1:0] filt;
  logic [FW-1:0] filt_next;
  logic [FW+1:0] filt_sum;
  logic [FW-1:0] raw_q;
  logic [SW-1:0] min_seen;
  logic [SW-1:0] min_next;
  logic [SW-1:0] level;
  logic [SW:0]   raised;
  logic [SW-1:0] sat;
  logic [SW-1:0] lifted;
  logic [SW-1:0] thresh_next;

  // Filter: 3/4 of the old level plus 1/4 of the new sample, in Q16.8.
  always_comb begin
    raw_q     = {raw, {acthr_pkg::FRAC_W{1'b0}}};
    filt_sum  = {2'b00, filt} + {1'b0, filt, 1'b0} + {2'b00, raw_q};
    filt_next = (filt == '0) ? raw_q : filt_sum[FW+1:2];
    level     = filt_next[FW-1:acthr_pkg::FRAC_W];
    min_next  = (level < min_seen) ? level : min_seen;
    raised    = {1'b0, min_next} + {1'b0, delta};
    sat       = raised[SW] ? {SW{1'b1}} : raised[SW-1:0];
    lifted    = (sat < thr_lo) ? thr_lo : sat;
    thresh_next = (lifted > thr_hi) ? thr_hi : lifted;
    changed   = (thresh_next != thresh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt     <= '0;
      min_seen <= '1;
      thresh   <= acthr_pkg::THRESH_INIT_RST;
    end else if (en) begin
      filt     <= filt_next;
      min_seen <= min_next;
      thresh   <= thresh_next;
    end
  end

endmodule

/* design/acthr_sched.sv */
`timescale 1ns / 1ps

module acthr_sched (
  input  logic                           clk,
  input  logic                           rst,
  input  acthr_pkg::sched_ctl_t          ctl,
  input  logic [acthr_pkg::TIME_W-1:0]   now,
  input  logic [acthr_pkg::CFG_W-1:0]    interval,
  output logic                           send
);

  localparam int unsigned TW = acthr_pkg::TIME_W;

  logic [TW-1:0] due_time;
  logic [TW-1:0] due_sched;
  logic [TW-1:0] due_next;
  logic          fire;

  // A zero due time means nothing is pending. Scheduling happens before the
  // check, so a zero interval fires in the same item.
  always_comb begin
    due_sched = (ctl.any_change && (due_time == '0))
                ? now + {{(TW - acthr_pkg::CFG_W){1'b0}}, interval} : due_time;
    fire      = (due_sched != '0) && (now >= due_sched);
    due_next  = fire ? '0 : due_sched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      due_time <= '0;
      send     <= 1'b0;
    end else if (ctl.en) begin
      due_time <= due_next;
      send     <= fire && !ctl.paused;
    end
  end

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !ctl.en |=> $stable(due_time) && $stable(send))
    else $error("scheduler state moved without an item");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    ctl.en && !ctl.any_change && (due_time == '0) |=> (due_time == '0) && !send)
    else $error("send raised with nothing pending");

  a_paused: assert property (@(posedge clk) disable iff (rst)
    ctl.en && ctl.paused |=> !send)
    else $error("send raised while paused");

endmodule

/* design/adaptive_cliff_threshold_tracker.sv */
`timescale 1ns / 1ps

// Adaptive cliff threshold tracker. Each input item carries NUM_SENSORS raw
// 16-bit cliff readings, a 32-bit millisecond timestamp and a flat flag; each
// item yields exactly one result item with the current per-channel detection
// thresholds, a send flag and the low-delta flag. Every channel smooths its
// reading with a 0.75 IIR filter in Q16.8, keeps the minimum filtered level,
// and sets its threshold to that minimum plus a delta that switches with
// hysteresis on dark surfaces or tilt, saturated and clamped to
// [threshold_min, threshold_max] (threshold_max wins if they cross). A
// threshold change with no send pending schedules one update_interval ms
// later; it fires on the first item whose timestamp reaches it, suppressed
// when paused. The block takes one item per clock cycle while m_axis_tready
// is high. An accepted item is held in the input register until the result
// slot is free, then its result is registered in the threshold, send and
// low-delta registers and m_axis_tvalid goes high; the per-item state update
// (filter, minimum, threshold and schedule) is combinational between the
// two. Thresholds reset to 800; threshold_initial is accepted on the
// configuration port but does not alter thresholds after reset.
// Configuration writes are to be made only while the block is idle.

module adaptive_cliff_threshold_tracker #(
  parameter int unsigned NUM_SENSORS = acthr_pkg::NUM_SENSORS_DEF,
  localparam int unsigned IN_BITS  = NUM_SENSORS * acthr_pkg::SAMPLE_W
                                     + acthr_pkg::TIME_W + 1,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = NUM_SENSORS * acthr_pkg::SAMPLE_W + 2,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0 up: raw reading of each sensor (front left, front
  // right, back left, back right), sample_time, pitch_flat, zero padding.
  input  logic [IN_W-1:0]                    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0 up: threshold of each sensor (same order as the
  // inputs), send_thresholds, low_delta_active, zero padding.
  output logic [OUT_W-1:0]                   m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [acthr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [acthr_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int unsigned SW = acthr_pkg::SAMPLE_W;
  localparam int unsigned RAW_BITS = NUM_SENSORS * SW;

  // Configuration registers.
  logic [SW-1:0] thresh_min;
  logic [SW-1:0] thresh_max;
  logic [SW-1:0] dark_level;
  logic [SW-1:0] delta_def;
  logic [SW-1:0] delta_low;
  logic [SW-1:0] interval;
  logic          paused;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_min <= acthr_pkg::THRESH_MIN_RST;
      thresh_max <= acthr_pkg::THRESH_MAX_RST;
      dark_level <= acthr_pkg::DARK_LEVEL_RST;
      delta_def  <= acthr_pkg::DELTA_DEF_RST;
      delta_low  <= acthr_pkg::DELTA_LOW_RST;
      interval   <= acthr_pkg::INTERVAL_RST;
      paused     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        acthr_pkg::REG_THRESH_MIN:  thresh_min <= cfg_wdata;
        acthr_pkg::REG_THRESH_MAX:  thresh_max <= cfg_wdata;
        // The initial threshold only matters at reset, where it is the
        // reset value, so a later write has no effect.
        acthr_pkg::REG_THRESH_INIT: ;
        acthr_pkg::REG_DARK_LEVEL:  dark_level <= cfg_wdata;
        acthr_pkg::REG_DELTA_DEF:   delta_def  <= cfg_wdata;
        acthr_pkg::REG_DELTA_LOW:   delta_low  <= cfg_wdata;
        acthr_pkg::REG_INTERVAL:    interval   <= cfg_wdata;
        acthr_pkg::REG_PAUSED:      paused     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register and handshake. The item advances into the state update
  // whenever the result slot is empty or being drained this cycle.
  logic                in_valid;
  logic [IN_BITS-1:0]  in_data;
  logic                out_valid;
  logic                advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata[IN_BITS-1:0];
    end
  end

  logic [acthr_pkg::TIME_W-1:0] now;
  logic                         flat;

  assign now  = in_data[RAW_BITS +: acthr_pkg::TIME_W];
  assign flat = in_data[RAW_BITS + acthr_pkg::TIME_W];

  // Delta hysteresis: all readings dark or tilted selects the low delta, all
  // readings at or above the dark level while flat selects the default.
  logic [NUM_SENSORS-1:0] is_dark;
  logic                   use_low;
  logic                   use_low_next;
  logic [SW-1:0]          delta;

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      is_dark[i] = (in_data[i*SW +: SW] < dark_level);
    end
    if ((&is_dark) || !flat) begin
      use_low_next = 1'b1;
    end else if (is_dark == '0) begin
      use_low_next = 1'b0;
    end else begin
      use_low_next = use_low;
    end
    delta = use_low_next ? delta_low : delta_def;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_low <= 1'b0;
    end else if (advance) begin
      use_low <= use_low_next;
    end
  end

  // Per-channel filter, minimum and threshold. The threshold registers
  // double as the result register for the threshold fields.
  logic [NUM_SENSORS-1:0] changed;
  logic [RAW_BITS-1:0]    thresh_all;

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_chan
    acthr_channel u_chan (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .raw     (in_data[g*SW +: SW]),
      .delta   (delta),
      .thr_lo  (thresh_min),
      .thr_hi  (thresh_max),
      .thresh  (thresh_all[g*SW +: SW]),
      .changed (changed[g])
    );
  end

  acthr_pkg::sched_ctl_t sched_ctl;
  logic                  send;

  assign sched_ctl.en         = advance;
  assign sched_ctl.any_change = |changed;
  assign sched_ctl.paused     = paused;

  acthr_sched u_sched (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sched_ctl),
    .now      (now),
    .interval (interval),
    .send     (send)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, use_low, send, thresh_all};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input refused with an empty input register");

  a_low_on_tilt: assert property (@(posedge clk) disable iff (rst)
    advance && !flat |=> use_low)
    else $error("low delta not selected while tilted");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("result missing after an item advanced");

endmodule
